/* src/tvms_pkg.sv */
package tvms_pkg;

    // message delimiters
    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_TAG_END   = 8'h3D;
    localparam logic [7:0] CH_VALUE_END = 8'h60;

    // result kinds
    localparam logic [1:0] KIND_TAG   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // field lengths and entry counts never exceed 64
    localparam int unsigned NUM_W = 7;

    // close request passed from front to back
    typedef struct packed {
        logic             run;
        logic             is_value;
        logic [NUM_W-1:0] len;
        logic [NUM_W-1:0] idx;
        logic             done;
        logic [NUM_W-1:0] count;
    } close_req_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_EMIT,
        B_DONE
    } back_state_t;

endpackage

/* src/tvms_queue.sv */
module tvms_queue import tvms_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    // front side
    input  logic             wr_bank,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             push,
    input  close_req_t       push_req,
    output logic             slot_busy,
    // back side
    input  logic             pop,
    output logic             head_valid,
    output close_req_t       head_req,
    input  logic [AW-1:0]    rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0]  buf_mem [2][DEPTH];
    close_req_t  req_reg [2];
    logic [1:0]  valid_reg;
    logic        rd_bank_reg;
    logic [7:0]  rd_data_reg;

    // one request slot per buffer bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            rd_bank_reg <= 1'b0;
        end else begin
            if (push) begin
                valid_reg[wr_bank] <= 1'b1;
            end
            if (pop) begin
                valid_reg[rd_bank_reg] <= 1'b0;
                rd_bank_reg            <= ~rd_bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            req_reg[wr_bank] <= push_req;
        end
    end

    // field byte store, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_bank][wr_addr] <= wr_data;
        end
        rd_data_reg <= buf_mem[rd_bank_reg][rd_addr];
    end

    assign slot_busy  = valid_reg[wr_bank];
    assign head_valid = valid_reg[rd_bank_reg];
    assign head_req   = req_reg[rd_bank_reg];
    assign rd_data    = rd_data_reg;

endmodule

/* src/tvms_front.sv */
module tvms_front import tvms_pkg::*; #(
    parameter int MAX_ENTRIES = 32,
    parameter int TAG_LIMIT   = 16,
    parameter int VALUE_LIMIT = 32,
    parameter int DEPTH       = 32,
    parameter int AW          = 5,
    parameter int LEN_W       = 6,
    parameter int CW          = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_msg_byte,
    input  logic          slot_busy,
    output logic          wr_bank,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          push,
    output close_req_t    push_req
);

    localparam logic [LEN_W-1:0] TAG_LIM = LEN_W'(TAG_LIMIT);
    localparam logic [LEN_W-1:0] VAL_LIM = LEN_W'(VALUE_LIMIT);
    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(DEPTH);
    localparam logic [CW-1:0]    CNT_MAX = CW'(MAX_ENTRIES);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic             full;
    logic             tag_fits, val_fits;
    logic [CW-1:0]    cnt_inc;

    assign s_ready  = ~slot_busy;
    assign accept   = s_valid & s_ready;
    assign full     = (cnt_reg >= CNT_MAX);
    assign tag_fits = (len_reg < TAG_LIM) && (len_reg < BUF_LEN);
    assign val_fits = (len_reg < VAL_LIM) && (len_reg < BUF_LEN);
    assign cnt_inc  = cnt_reg + CW'(1);

    // classify the incoming byte, store field bytes and build the close request
    always_comb begin
        len_next = len_reg;
        cnt_next = cnt_reg;
        bank_next = bank_reg;
        wr_en    = 1'b0;
        push     = 1'b0;
        push_req = '0;
        push_req.len = NUM_W'(len_reg);
        push_req.idx = NUM_W'(cnt_reg);
        if (accept) begin
            if (s_msg_byte == CH_END) begin
                push_req.run      = ~full & val_fits;
                push_req.is_value = 1'b1;
                push_req.done     = 1'b1;
                push_req.count    = (~full & val_fits) ? NUM_W'(cnt_inc) : NUM_W'(cnt_reg);
                push      = 1'b1;
                bank_next = ~bank_reg;
                len_next  = '0;
                cnt_next  = '0;
            end else if (!full) begin
                if (s_msg_byte == CH_TAG_END) begin
                    push_req.run = tag_fits;
                    push      = tag_fits;
                    bank_next = bank_reg ^ tag_fits;
                    len_next  = '0;
                end else if (s_msg_byte == CH_VALUE_END) begin
                    push_req.run      = val_fits;
                    push_req.is_value = 1'b1;
                    push      = val_fits;
                    bank_next = bank_reg ^ val_fits;
                    len_next  = '0;
                    if (val_fits) begin
                        cnt_next = cnt_inc;
                    end
                end else if (len_reg < BUF_LEN) begin
                    wr_en    = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
    end

    assign wr_bank = bank_reg;
    assign wr_addr = len_reg[AW-1:0];
    assign wr_data = s_msg_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            len_reg  <= len_next;
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
        end
    end

endmodule

/* src/tvms_back.sv */
module tvms_back import tvms_pkg::*; #(
    parameter int AW    = 5,
    parameter int LEN_W = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  close_req_t    head_req,
    output logic          pop,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_field_kind,
    output logic [4:0]    m_entry_index,
    output logic [4:0]    m_char_pos,
    output logic [7:0]    m_char_byte,
    output logic          m_run_last,
    output logic [5:0]    m_entry_count
);

    back_state_t      state_reg, state_next;
    close_req_t       req_reg, req_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [4:0]       idx_reg, idx_next;
    logic [4:0]       cpos_reg, cpos_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic [5:0]       count_reg, count_next;
    logic             load_ok;
    logic             load;
    logic             at_end;
    logic [NUM_W-1:0] pos_w;

    assign load_ok = ~m_valid_reg | m_ready;
    assign pos_w   = NUM_W'(pos_reg);
    assign at_end  = (pos_w == req_reg.len);
    assign rd_addr = pos_reg[AW-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        pos_next   = pos_reg;
        case (state_reg)
            B_IDLE: begin
                if (head_valid) begin
                    req_next   = head_req;
                    pos_next   = '0;
                    state_next = head_req.run ? B_READ : B_DONE;
                end
            end
            B_READ: begin
                state_next = B_EMIT;
            end
            B_EMIT: begin
                if (load_ok) begin
                    if (at_end) begin
                        state_next = req_reg.done ? B_DONE : B_IDLE;
                    end else begin
                        pos_next   = pos_reg + LEN_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            B_DONE: begin
                if (load_ok) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // result register load and queue release
    always_comb begin
        load       = 1'b0;
        pop        = 1'b0;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        cpos_next  = cpos_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        count_next = count_reg;
        case (state_reg)
            B_EMIT: begin
                if (load_ok) begin
                    load       = 1'b1;
                    pop        = at_end & ~req_reg.done;
                    kind_next  = req_reg.is_value ? KIND_VALUE : KIND_TAG;
                    idx_next   = req_reg.idx[4:0];
                    cpos_next  = pos_w[4:0];
                    char_next  = at_end ? 8'h00 : rd_data;
                    last_next  = at_end;
                    count_next = '0;
                end
            end
            B_DONE: begin
                if (load_ok) begin
                    load       = 1'b1;
                    pop        = 1'b1;
                    kind_next  = KIND_DONE;
                    idx_next   = '0;
                    cpos_next  = '0;
                    char_next  = 8'h00;
                    last_next  = 1'b1;
                    count_next = req_reg.count[5:0];
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
        m_valid_next = load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        pos_reg   <= pos_next;
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        cpos_reg  <= cpos_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_field_kind  = kind_reg;
    assign m_entry_index = idx_reg;
    assign m_char_pos    = cpos_reg;
    assign m_char_byte   = char_reg;
    assign m_run_last    = last_reg;
    assign m_entry_count = count_reg;

endmodule

/* src/tag_value_message_splitter.sv */
// path: closing byte, queue slot, back idle, read and emit states, result register; bare done:
// idle then done. throughput: one byte per cycle into the front unless slot_busy; the back visits
// idle per request, read and emit per character (registered buffer read), done for a done result
// two buffer banks let the front fill one field while the back drains the previous one
// reset: synchronous active-low aresetn clears counts, bank pointers, state and output valid
module tag_value_message_splitter import tvms_pkg::*; #(
    parameter int MAX_ENTRIES = 32,
    parameter int TAG_LIMIT   = 16,
    parameter int VALUE_LIMIT = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_msg_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_field_kind,
    output logic [4:0] m_entry_index,
    output logic [4:0] m_char_pos,
    output logic [7:0] m_char_byte,
    output logic       m_run_last,
    output logic [5:0] m_entry_count
);

    localparam int DEPTH = (TAG_LIMIT > VALUE_LIMIT) ? TAG_LIMIT : VALUE_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);

    logic          wr_bank;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          push;
    close_req_t    push_req;
    logic          slot_busy;
    logic          pop;
    logic          head_valid;
    close_req_t    head_req;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // byte intake and field classification
    tvms_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_LIMIT   (TAG_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT),
        .DEPTH       (DEPTH),
        .AW          (AW),
        .LEN_W       (LEN_W),
        .CW          (CW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_msg_byte (s_msg_byte),
        .slot_busy  (slot_busy),
        .wr_bank    (wr_bank),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_req   (push_req)
    );

    // banked field buffer and close request queue
    tvms_queue #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_bank    (wr_bank),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_req   (push_req),
        .slot_busy  (slot_busy),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // run emission
    tvms_back #(
        .AW    (AW),
        .LEN_W (LEN_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_req      (head_req),
        .pop           (pop),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_kind  (m_field_kind),
        .m_entry_index (m_entry_index),
        .m_char_pos    (m_char_pos),
        .m_char_byte   (m_char_byte),
        .m_run_last    (m_run_last),
        .m_entry_count (m_entry_count)
    );

endmodule
